[rtl/gas_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gas_pkg
// shared types and constants of the graph adjacency store
// ----------------------------------------------------------------------------
package gas_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int WEIGHT_BITS  = 16;
    localparam int VB           = $clog2(MAX_VERTICES + 1);
    localparam int SQ_DEPTH     = MAX_VERTICES * MAX_VERTICES;
    localparam int TRI_DEPTH    = (MAX_VERTICES * (MAX_VERTICES + 1)) / 2 + 1;
    localparam int SQ_AW        = $clog2(SQ_DEPTH);
    localparam int TRI_AW       = $clog2(TRI_DEPTH);

    localparam logic [2:0] ACT_GET     = 3'd0;
    localparam logic [2:0] ACT_ADD     = 3'd1;
    localparam logic [2:0] ACT_DEL     = 3'd2;
    localparam logic [2:0] ACT_DEGREE  = 3'd3;
    localparam logic [2:0] ACT_ADD_V   = 3'd4;
    localparam logic [2:0] ACT_DEL_V   = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EXIST = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_DECIDE,
        S_WALK,
        S_DRAIN,
        S_OUT
    } state_t;

    // one memory access request
    typedef struct packed {
        logic              sq_we;
        logic              tri_we;
        logic [SQ_AW-1:0]  sq_addr;
        logic [TRI_AW-1:0] tri_addr;
        logic [15:0]       wdata;
    } mem_req_t;

endpackage
`default_nettype wire

[rtl/gas_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gas_mem
// square and triangle edge memories with registered read data
// ----------------------------------------------------------------------------
module gas_mem
    import gas_pkg::*;
(
    input  wire logic     clk,
    input  wire mem_req_t req,
    output logic [15:0]   sq_rdata,
    output logic [15:0]   tri_rdata
);

    logic [15:0] sq_mem  [SQ_DEPTH];
    logic [15:0] tri_mem [TRI_DEPTH];

    // square store port
    always_ff @(posedge clk)
    begin
        if (req.sq_we)
        begin
            sq_mem[req.sq_addr] <= req.wdata;
        end
        sq_rdata <= sq_mem[req.sq_addr];
    end

    // triangle store port
    always_ff @(posedge clk)
    begin
        if (req.tri_we)
        begin
            tri_mem[req.tri_addr] <= req.wdata;
        end
        tri_rdata <= tri_mem[req.tri_addr];
    end

endmodule
`default_nettype wire

[rtl/graph_adjacency_store_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// steps after an item is taken: get/add edge read the store, then decide; delete
//   edge and out-of-range items go straight to the result; degree walks k over
//   1..vertex count; vertex add and delete clear a row and a column per vertex
// throughput: one item at a time, the next beat is taken in the cycle after the
//   result is loaded; the vertex clear walk over one memory port sets the rate
// reset: a pass over the SQ_DEPTH (4096) addresses first zeroes both stores
module graph_adjacency_store_unit
    import gas_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // action[2:0], vertex_a[9:3], vertex_b[16:10], weight[32:17], zero fill
    input  wire logic [39:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // value[15:0], status[17:16], zero fill
    output logic [23:0]      m_tdata
);

    state_t            state_reg, state_next;
    logic              mode_reg;
    logic [VB-1:0]     vcount_reg, vcount_next;
    logic [2:0]        act_reg;
    logic [6:0]        a_reg, b_reg;
    logic [15:0]       w_reg;
    logic [SQ_AW:0]    clr_reg, clr_next;
    logic [VB-1:0]     k_reg, k_next;
    logic              phase_reg, phase_next;
    logic [15:0]       val_reg, val_next;
    logic [1:0]        stat_reg, stat_next;
    logic              cnt_reg, cnt_next;
    logic              skip_reg, skip_next;
    logic [15:0]       out_val_reg;
    logic [1:0]        out_stat_reg;
    logic              out_valid_reg;
    logic              done;
    mem_req_t          req;
    logic [15:0]       sq_rdata, tri_rdata;

    function automatic logic [SQ_AW-1:0] sq_idx(input logic [6:0] a, input logic [6:0] b);
        logic [SQ_AW+7:0] t;
        t = ({{(SQ_AW+1){1'b0}}, a} - 1'b1) * (SQ_AW+8)'(MAX_VERTICES)
            + {{(SQ_AW+1){1'b0}}, b} - 1'b1;
        return t[SQ_AW-1:0];
    endfunction

    function automatic logic [TRI_AW-1:0] tri_idx(input logic [6:0] a, input logic [6:0] b);
        logic [6:0]  i, j;
        logic [15:0] t;
        i = (a > b) ? b : a;
        j = (a > b) ? a : b;
        t = (({9'd0, j} * ({9'd0, j} - 16'd1)) >> 1) + {9'd0, i};
        return t[TRI_AW-1:0];
    endfunction

    function automatic logic [15:0] wrap_w(input logic [15:0] w);
        logic [WEIGHT_BITS-1:0] n;
        n = WEIGHT_BITS'($signed(w));
        return 16'($signed(n));
    endfunction

    function automatic logic ok(input logic [6:0] v);
        return (v != 7'd0) && ({1'b0, v} <= 8'(MAX_VERTICES));
    endfunction

    logic [6:0] kv;
    assign kv = 7'(k_reg);

    gas_mem u_mem (
        .clk       (clk),
        .req       (req),
        .sq_rdata  (sq_rdata),
        .tri_rdata (tri_rdata)
    );

    logic [15:0] rd;
    assign rd = mode_reg ? sq_rdata : tri_rdata;
    assign done = (state_reg == S_OUT) && (!out_valid_reg || m_tready);

    // next state and work registers
    always_comb
    begin
        state_next  = state_reg;
        vcount_next = vcount_reg;
        clr_next    = clr_reg;
        k_next      = k_reg;
        phase_next  = phase_reg;
        val_next    = val_reg;
        stat_next   = stat_reg;
        cnt_next    = 1'b0;
        skip_next   = 1'b1;
        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (SQ_AW+1)'(SQ_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    val_next   = 16'd0;
                    stat_next  = ST_OK;
                    k_next     = VB'(1);
                    phase_next = 1'b0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_OUT;
                case (act_reg)
                    ACT_GET, ACT_ADD, ACT_DEL:
                    begin
                        if (!ok(a_reg) || !ok(b_reg))
                        begin
                            stat_next = ST_RANGE;
                        end
                        else if (act_reg != ACT_DEL)
                        begin
                            state_next = S_DECIDE;
                        end
                    end
                    ACT_DEGREE:
                    begin
                        if (a_reg == 7'd0 || {1'b0, a_reg} > 8'(vcount_reg) || !ok(a_reg))
                        begin
                            stat_next = ST_RANGE;
                        end
                        else
                        begin
                            state_next = S_WALK;
                        end
                    end
                    ACT_ADD_V:
                    begin
                        if (vcount_reg >= VB'(MAX_VERTICES))
                        begin
                            stat_next = ST_RANGE;
                        end
                        else
                        begin
                            vcount_next = vcount_reg + 1'b1;
                            state_next  = S_WALK;
                        end
                    end
                    ACT_DEL_V:
                    begin
                        if (!ok(a_reg))
                        begin
                            stat_next = ST_RANGE;
                        end
                        else
                        begin
                            if (vcount_reg != '0)
                            begin
                                vcount_next = vcount_reg - 1'b1;
                            end
                            state_next = S_WALK;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_DECIDE:
            begin
                state_next = S_OUT;
                if (act_reg == ACT_GET)
                begin
                    val_next = rd;
                end
                else if (rd != 16'd0)
                begin
                    stat_next = ST_EXIST;
                end
            end
            S_WALK:
            begin
                // degree: k over 1..vcount, read issued now, counted next cycle
                if (act_reg == ACT_DEGREE)
                begin
                    cnt_next  = 1'b1;
                    skip_next = !mode_reg && (kv == a_reg);
                    k_next    = k_reg + 1'b1;
                    if (k_reg == vcount_reg)
                    begin
                        state_next = S_DRAIN;
                    end
                end
                else
                begin
                    // vertex clear: two writes per k (row and column)
                    phase_next = !phase_reg;
                    if (phase_reg)
                    begin
                        k_next = k_reg + 1'b1;
                        if (k_reg == VB'(MAX_VERTICES))
                        begin
                            state_next = S_OUT;
                        end
                    end
                end
            end
            S_DRAIN:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (cnt_reg && !skip_reg && rd != 16'd0)
        begin
            val_next = val_reg + 1'b1;
        end
    end

    // memory request
    logic [6:0] va;
    assign va = (act_reg == ACT_ADD_V) ? 7'(vcount_reg) : a_reg;
    always_comb
    begin
        req.sq_we    = 1'b0;
        req.tri_we   = 1'b0;
        req.wdata    = 16'd0;
        req.sq_addr  = sq_idx(a_reg, b_reg);
        req.tri_addr = tri_idx(a_reg, b_reg);
        case (state_reg)
            S_CLEAR:
            begin
                req.sq_we    = 1'b1;
                req.tri_we   = clr_reg < (SQ_AW+1)'(TRI_DEPTH);
                req.sq_addr  = clr_reg[SQ_AW-1:0];
                req.tri_addr = clr_reg[TRI_AW-1:0];
            end
            S_READ:
            begin
                if (act_reg == ACT_DEL && ok(a_reg) && ok(b_reg))
                begin
                    req.sq_we  = mode_reg;
                    req.tri_we = !mode_reg;
                end
            end
            S_DECIDE:
            begin
                if (act_reg == ACT_ADD && rd == 16'd0)
                begin
                    req.sq_we  = mode_reg;
                    req.tri_we = !mode_reg;
                    req.wdata  = wrap_w(w_reg);
                end
            end
            S_WALK:
            begin
                if (act_reg == ACT_DEGREE)
                begin
                    req.sq_addr  = sq_idx(a_reg, kv);
                    req.tri_addr = tri_idx(a_reg, kv);
                end
                else
                begin
                    req.sq_we    = 1'b1;
                    req.tri_we   = !phase_reg;
                    req.sq_addr  = phase_reg ? sq_idx(kv, va) : sq_idx(va, kv);
                    req.tri_addr = tri_idx(va, kv);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_stat_reg, out_val_reg};

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            mode_reg      <= 1'b0;
            vcount_reg    <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            vcount_reg <= vcount_next;
            clr_reg    <= clr_next;
            cnt_reg    <= cnt_next;
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        k_reg     <= k_next;
        phase_reg <= phase_next;
        val_reg   <= val_next;
        stat_reg  <= stat_next;
        skip_reg  <= skip_next;
        if (s_tvalid && s_tready)
        begin
            act_reg <= s_tdata[2:0];
            a_reg   <= s_tdata[9:3];
            b_reg   <= s_tdata[16:10];
            w_reg   <= s_tdata[32:17];
        end
        if (done)
        begin
            out_val_reg  <= val_reg;
            out_stat_reg <= stat_reg;
        end
    end

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !s_tready)
        else $error("input taken during clearing pass");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vcount_reg <= VB'(MAX_VERTICES))
        else $error("vertex count above maximum");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");
`endif

endmodule
`default_nettype wire

[dv/graph_adjacency_store_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_adjacency_store_checker
// watches the config port and both stream channels, keeps its own copy of the
// square and triangle edge stores, predicts one result beat per input beat
// and compares each output beat field by field against the oldest prediction
// ----------------------------------------------------------------------------
module graph_adjacency_store_checker
    import gas_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic        cfg_wdata,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [39:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,
    output int               fail_count,
    output int               pending,
    output int               results_seen
);

    // status in the upper bits, value in the lower, as on m_tdata
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] value;
    } edge_result_t;

    logic signed [15:0] sq_weights [SQ_DEPTH];
    logic signed [15:0] tri_weights [TRI_DEPTH];
    int                 num_vertices;
    logic               directed;
    edge_result_t       expected_results [$];

    assign pending = expected_results.size();

    function automatic int sq_slot(int a, int b);
        return ((a - 1) * MAX_VERTICES + (b - 1)) % SQ_DEPTH;
    endfunction

    function automatic int tri_slot(int a, int b);
        int i;
        int j;
        i = (a < b) ? a : b;
        j = (a < b) ? b : a;
        return ((j * (j - 1)) / 2 + i) % TRI_DEPTH;
    endfunction

    function automatic bit vertex_ok(int v);
        return v >= 1 && v <= MAX_VERTICES;
    endfunction

    // wipe every edge touching vertex v in both stores
    task automatic wipe_vertex(int v);
        for (int k = 1; k <= MAX_VERTICES; k++)
        begin
            sq_weights[sq_slot(v, k)] = '0;
            sq_weights[sq_slot(k, v)] = '0;
            tri_weights[tri_slot(v, k)] = '0;
        end
    endtask

    // apply one operation to the store copy and work out its result
    task automatic run_graph_op(input logic [39:0] beat, output edge_result_t res);
        logic [2:0]         act;
        int                 a;
        int                 b;
        logic signed [15:0] w;
        logic signed [15:0] cur;
        int                 cnt;
        act = beat[2:0];
        a   = beat[9:3];
        b   = beat[16:10];
        w   = beat[32:17];
        res = '0;
        cnt = 0;
        cur = '0;
        if (vertex_ok(a) && vertex_ok(b))
            cur = directed ? sq_weights[sq_slot(a, b)] : tri_weights[tri_slot(a, b)];
        case (act)
            ACT_GET:
            begin
                if (!vertex_ok(a) || !vertex_ok(b))
                    res.status = ST_RANGE;
                else
                    res.value = cur;
            end
            ACT_ADD:
            begin
                if (!vertex_ok(a) || !vertex_ok(b))
                    res.status = ST_RANGE;
                else if (cur != 0)
                    res.status = ST_EXIST;
                else if (directed)
                    sq_weights[sq_slot(a, b)] = w;
                else
                    tri_weights[tri_slot(a, b)] = w;
            end
            ACT_DEL:
            begin
                if (!vertex_ok(a) || !vertex_ok(b))
                    res.status = ST_RANGE;
                else if (directed)
                    sq_weights[sq_slot(a, b)] = '0;
                else
                    tri_weights[tri_slot(a, b)] = '0;
            end
            ACT_DEGREE:
            begin
                if (a < 1 || a > num_vertices)
                    res.status = ST_RANGE;
                else
                begin
                    for (int k = 1; k <= num_vertices; k++)
                    begin
                        if (directed)
                        begin
                            if (sq_weights[sq_slot(a, k)] != 0)
                                cnt++;
                        end
                        else if (k != a && tri_weights[tri_slot(a, k)] != 0)
                            cnt++;
                    end
                    res.value = 16'(cnt);
                end
            end
            ACT_ADD_V:
            begin
                if (num_vertices >= MAX_VERTICES)
                    res.status = ST_RANGE;
                else
                begin
                    num_vertices++;
                    wipe_vertex(num_vertices);
                end
            end
            ACT_DEL_V:
            begin
                if (!vertex_ok(a))
                    res.status = ST_RANGE;
                else
                begin
                    wipe_vertex(a);
                    if (num_vertices > 0)
                        num_vertices--;
                end
            end
            default:
                res = '0;
        endcase
    endtask

    // track config, predict on input beats, compare on output beats
    always @(posedge clk or negedge rst_n)
    begin
        edge_result_t want;
        edge_result_t got;
        if (!rst_n)
        begin
            foreach (sq_weights[i])
                sq_weights[i] = '0;
            foreach (tri_weights[i])
                tri_weights[i] = '0;
            num_vertices = 0;
            directed     = 1'b0;
            fail_count   = 0;
            results_seen = 0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_we)
                directed = cfg_wdata;
            if (s_tvalid && s_tready)
            begin
                run_graph_op(s_tdata, want);
                expected_results.push_back(want);
            end
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                got = m_tdata[17:0];
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result beat value=%h status=%0d",
                                 got.value, got.status);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.value !== want.value || got.status !== want.status)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("result %0d: value exp %h got %h, status exp %0d got %0d",
                                     results_seen, want.value, got.value,
                                     want.status, got.status);
                    end
                end
            end
        end
    end

endmodule

[dv/graph_adjacency_store_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_adjacency_store_unit_test
// drives edge and vertex operations into the graph store in both storage
// modes, with random idling on both sides and one long output hold-off;
// the checker beside the block predicts and compares every result beat
// ----------------------------------------------------------------------------
module graph_adjacency_store_unit_test;
    import gas_pkg::*;

    localparam int QUIET_LIMIT = 20000;
    localparam int DRAIN_WAIT  = MAX_VERTICES + 40;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    int          fail_count;
    int          pending;
    int          results_seen;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_off;
    int          quiet_cycles;
    int          items_sent;

    graph_adjacency_store_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    graph_adjacency_store_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver: random stalls plus an optional long hold-off
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off > 0)
            begin
                hold_off--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog on cycles with no beat on either side
    initial
    begin
        quiet_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else if (++quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
                $display("graph_adjacency_store_unit: mismatch");
                $finish;
            end
        end
    end

    // offer one operation beat and wait for it to be taken
    task automatic send_op(logic [2:0] act, logic [6:0] a, logic [6:0] b, logic [15:0] w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, w, b, a, act};
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
        @(negedge clk);
    endtask

    // let the block go idle, then write the mode register
    task automatic set_mode(logic mode);
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_WAIT) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [6:0] pick_vertex();
        int r;
        r = $urandom_range(99);
        if (r < 4)
            return 7'd0;
        if (r < 8)
            return 7'($urandom_range(127, MAX_VERTICES + 1));
        if (r < 30)
            return 7'($urandom_range(8, 1));
        return 7'($urandom_range(MAX_VERTICES, 1));
    endfunction

    function automatic logic [15:0] pick_weight();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return 16'h0000;
        if (r < 12)
            return 16'h8000;
        if (r < 16)
            return 16'h7fff;
        return 16'($urandom());
    endfunction

    // mostly edge traffic on in-range vertices, some vertex churn and noise
    task automatic send_random(int count);
        int          r;
        logic [2:0]  act;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            if (r < 20)      act = ACT_GET;
            else if (r < 50) act = ACT_ADD;
            else if (r < 60) act = ACT_DEL;
            else if (r < 78) act = ACT_DEGREE;
            else if (r < 90) act = ACT_ADD_V;
            else if (r < 96) act = ACT_DEL_V;
            else             act = 3'($urandom_range(7, 6));
            send_op(act, pick_vertex(), pick_vertex(), pick_weight());
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off      = 0;
        items_sent    = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // directed cases in undirected mode
        set_mode(1'b0);
        send_op(ACT_GET, 7'd1, 7'd1, 16'h0000);
        send_op(ACT_ADD, 7'd1, 7'd1, 16'h7fff);
        send_op(ACT_ADD, 7'd1, 7'd1, 16'h1234);
        send_op(ACT_GET, 7'd1, 7'd1, 16'h0000);
        send_op(ACT_ADD, 7'd64, 7'd64, 16'h8000);
        send_op(ACT_GET, 7'd64, 7'd64, 16'h0000);
        send_op(ACT_ADD, 7'd0, 7'd5, 16'h0001);
        send_op(ACT_ADD, 7'd5, 7'd127, 16'h0001);
        send_op(ACT_GET, 7'd65, 7'd1, 16'h0000);
        send_op(ACT_DEL, 7'd1, 7'd1, 16'h0000);
        send_op(ACT_DEGREE, 7'd1, 7'd0, 16'h0000);
        send_op(ACT_ADD_V, 7'd0, 7'd0, 16'h0000);
        send_op(ACT_ADD_V, 7'd0, 7'd0, 16'h0000);
        send_op(ACT_ADD, 7'd1, 7'd2, 16'hffff);
        send_op(ACT_GET, 7'd2, 7'd1, 16'h0000);
        send_op(ACT_DEGREE, 7'd1, 7'd0, 16'h0000);
        send_op(ACT_DEGREE, 7'd3, 7'd0, 16'h0000);
        send_op(ACT_ADD, 7'd2, 7'd2, 16'h0000);
        send_op(ACT_GET, 7'd2, 7'd2, 16'h0000);
        send_op(ACT_DEL_V, 7'd1, 7'd0, 16'h0000);
        send_op(ACT_DEL_V, 7'd0, 7'd0, 16'h0000);
        send_op(ACT_DEL_V, 7'd127, 7'd0, 16'h0000);
        send_op(3'd6, 7'd3, 7'd4, 16'h5555);
        send_op(3'd7, 7'd127, 7'd127, 16'haaaa);

        // sender rarely idle, receiver mostly stalled, directed mode
        set_mode(1'b1);
        send_idle_pct = 6;
        recv_idle_pct = 74;
        send_random(650);

        // roles swapped, back to the triangle store
        set_mode(1'b0);
        send_idle_pct = 74;
        recv_idle_pct = 6;
        send_random(650);

        // no idling, with one long output hold-off while beats keep coming
        set_mode(1'b1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off      = 400;
        send_random(350);
        set_mode(1'b0);
        send_random(350);

        // drain
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_WAIT) @(negedge clk);

        $display("covered %0d operation beats, %0d result beats, both storage modes,",
                 items_sent, results_seen);
        $display("range, existing-edge, full-store and vertex-delete cases under stalls");
        if (fail_count == 0)
            $display("graph_adjacency_store_unit: match");
        else
            $display("graph_adjacency_store_unit: mismatch");
        $finish;
    end

endmodule
